// ===== hdl/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define CTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also runs during reset
`define CTS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/cts_pkg.sv =====
// types, constants and register codes of the capacitive touch sensor
package cts_pkg;

  // charge/discharge rounds per measurement
  localparam int REPETITIONS = 4;
  localparam int ROUND_W = (REPETITIONS > 1) ? $clog2(REPETITIONS) : 1;

  localparam int DATA_W = 16;
  localparam int ACC_W = 32;
  localparam int CFG_IDX_W = 2;

  // register reset values
  localparam logic [DATA_W-1:0] GAIN_RST = 16'd4588;
  localparam logic [DATA_W-1:0] THRESH_RST = 16'd300;
  localparam logic [DATA_W-1:0] SETTLE_RST = 16'd1000;

  typedef enum logic [1:0] {
    PH_CHARGE    = 2'd0,
    PH_HOLD_HI   = 2'd1,
    PH_DISCHARGE = 2'd2,
    PH_HOLD_LO   = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN   = 2'd0,
    CFG_THRESH = 2'd1,
    CFG_SETTLE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] gain;
    logic [DATA_W-1:0] thresh;
    logic [DATA_W-1:0] settle;
  } cfg_t;

  // per-tick result of the sequencer, without the filter output
  typedef struct packed {
    logic              drive_level;
    logic              done_res;
    logic [DATA_W-1:0] rise_sum;
    logic [DATA_W-1:0] fall_sum;
    logic              touched;
  } step_t;

endpackage

// ===== hdl/cts_stream_if.sv =====
// valid/ready stream interfaces for the sample and result channels
interface cts_in_if;
  logic valid;
  logic ready;
  logic sense_level;

  modport source (output valid, output sense_level, input ready);
  modport sink (input valid, input sense_level, output ready);
endinterface

interface cts_out_if;
  logic                      valid;
  logic                      ready;
  logic                      drive_level;
  logic                      done_res;
  logic [cts_pkg::DATA_W-1:0] rise_sum;
  logic [cts_pkg::DATA_W-1:0] fall_sum;
  logic [cts_pkg::DATA_W-1:0] smoothed;
  logic                      touched;

  modport source (output valid, output drive_level, output done_res, output rise_sum,
                  output fall_sum, output smoothed, output touched, input ready);
  modport sink (input valid, input drive_level, input done_res, input rise_sum,
                input fall_sum, input smoothed, input touched, output ready);
endinterface

// ===== hdl/capacitive_touch_sensor.sv =====
// RC charge-time touch sensor. Each accepted request on in_if is one sampling tick of the
// sense pin and yields exactly one result on out_if carrying the charge pin level for that
// tick, the last measurement's rise and fall sums, the touch flag and the filtered rise sum.
// One request is taken every clock while out_if is ready; results pass through st1_r,
// st2_r and sto_r, beside the filter's operand and product registers; the whole pipeline
// holds while out_if stalls. A measurement spans REPETITIONS charge/discharge rounds;
// done_res marks the tick that completes it. The user must write the cfg_ port registers
// (gain, threshold, settle ticks) only while no requests are in flight; it is not enforced.
module capacitive_touch_sensor (
  input  logic                          clk,
  input  logic                          rst_n,
  cts_in_if.sink                        in_if,
  cts_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [cts_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [cts_pkg::DATA_W-1:0]    cfg_data
);

  cts_pkg::cfg_t              cfg_r;
  cts_pkg::step_t             step;
  cts_pkg::step_t             st1_r, st2_r, sto_r;
  logic                       v1_r, v2_r, out_valid_r;
  logic [cts_pkg::DATA_W-1:0] smoothed_nxt, smoothed_r;
  logic                       en, fire;

  // pipeline advances whenever the result register is free or drained
  assign en   = !out_valid_r || out_if.ready;
  assign fire = in_if.valid && en;
  assign in_if.ready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain   <= cts_pkg::GAIN_RST;
      cfg_r.thresh <= cts_pkg::THRESH_RST;
      cfg_r.settle <= cts_pkg::SETTLE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        cts_pkg::CFG_GAIN:   cfg_r.gain   <= cfg_data;
        cts_pkg::CFG_THRESH: cfg_r.thresh <= cfg_data;
        cts_pkg::CFG_SETTLE: cfg_r.settle <= cfg_data;
        default: ;
      endcase
    end
  end

  cts_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (fire),
    .sense_level (in_if.sense_level),
    .cfg         (cfg_r),
    .step        (step)
  );

  cts_filt u_filt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .load     (fire && step.done_res),
    .x        (step.rise_sum),
    .gain     (cfg_r.gain),
    .smoothed (smoothed_nxt)
  );

  // valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= fire;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      st1_r      <= step;
      st2_r      <= st1_r;
      sto_r      <= st2_r;
      smoothed_r <= smoothed_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.drive_level = sto_r.drive_level;
  assign out_if.done_res    = sto_r.done_res;
  assign out_if.rise_sum    = sto_r.rise_sum;
  assign out_if.fall_sum    = sto_r.fall_sum;
  assign out_if.smoothed    = smoothed_r;
  assign out_if.touched     = sto_r.touched;

endmodule

// ===== hdl/cts_seq.sv =====
// charge / discharge measurement sequencer with counters and touch decision
module cts_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic                sense_level,
  input  cts_pkg::cfg_t       cfg,
  output cts_pkg::step_t      step
);

  localparam logic [cts_pkg::ROUND_W:0] REP_CNT =
    (cts_pkg::ROUND_W + 1)'(cts_pkg::REPETITIONS);

  cts_pkg::phase_t               phase_r, phase_nxt;
  logic [cts_pkg::DATA_W-1:0]    rise_r, rise_nxt;
  logic [cts_pkg::DATA_W-1:0]    fall_r, fall_nxt;
  logic [cts_pkg::DATA_W-1:0]    wait_r, wait_nxt;
  logic [cts_pkg::ROUND_W-1:0]   round_r, round_nxt;
  logic [cts_pkg::DATA_W-1:0]    last_rise_r, last_rise_nxt;
  logic [cts_pkg::DATA_W-1:0]    last_fall_r, last_fall_nxt;
  logic                          touch_r, touch_nxt;
  logic [cts_pkg::DATA_W-1:0]    rise_inc, fall_inc, wait_inc;
  logic [cts_pkg::ROUND_W:0]     round_inc;
  logic                          drive, done, end_rnd;

  // saturating increments of the counters, plain increment of the round
  assign rise_inc = (rise_r != '1) ? rise_r + 16'd1 : rise_r;
  assign fall_inc = (fall_r != '1) ? fall_r + 16'd1 : fall_r;
  assign wait_inc = (wait_r != '1) ? wait_r + 16'd1 : wait_r;
  assign round_inc = {1'b0, round_r} + (cts_pkg::ROUND_W + 1)'(1);

  // next state and outputs
  always_comb begin
    phase_nxt     = phase_r;
    rise_nxt      = rise_r;
    fall_nxt      = fall_r;
    wait_nxt      = wait_r;
    round_nxt     = round_r;
    last_rise_nxt = last_rise_r;
    last_fall_nxt = last_fall_r;
    touch_nxt     = touch_r;
    drive         = 1'b0;
    done          = 1'b0;
    end_rnd       = 1'b0;

    case (phase_r)
      cts_pkg::PH_CHARGE: begin
        drive = 1'b1;
        if (!sense_level) begin
          rise_nxt = rise_inc;
        end else if (cfg.settle == '0) begin
          phase_nxt = cts_pkg::PH_DISCHARGE;
        end else begin
          wait_nxt  = '0;
          phase_nxt = cts_pkg::PH_HOLD_HI;
        end
      end
      cts_pkg::PH_HOLD_HI: begin
        drive    = 1'b1;
        wait_nxt = wait_inc;
        if (wait_inc >= cfg.settle) phase_nxt = cts_pkg::PH_DISCHARGE;
      end
      cts_pkg::PH_DISCHARGE: begin
        if (sense_level) begin
          fall_nxt = fall_inc;
        end else if (cfg.settle == '0) begin
          end_rnd = 1'b1;
        end else begin
          wait_nxt  = '0;
          phase_nxt = cts_pkg::PH_HOLD_LO;
        end
      end
      cts_pkg::PH_HOLD_LO: begin
        wait_nxt = wait_inc;
        if (wait_inc >= cfg.settle) end_rnd = 1'b1;
      end
      default: begin
        phase_nxt = cts_pkg::PH_CHARGE;
      end
    endcase

    // end of a round, or of the whole measurement
    if (end_rnd) begin
      phase_nxt = cts_pkg::PH_CHARGE;
      if (round_inc < REP_CNT) begin
        round_nxt = round_inc[cts_pkg::ROUND_W-1:0];
      end else begin
        done          = 1'b1;
        last_rise_nxt = rise_r;
        last_fall_nxt = fall_r;
        touch_nxt     = (rise_r > cfg.thresh);
        rise_nxt      = '0;
        fall_nxt      = '0;
        round_nxt     = '0;
        wait_nxt      = '0;
      end
    end
  end

  assign step.drive_level = drive;
  assign step.done_res    = done;
  assign step.rise_sum    = last_rise_nxt;
  assign step.fall_sum    = last_fall_nxt;
  assign step.touched     = touch_nxt;

  // state registers, advanced once per accepted sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cts_pkg::PH_CHARGE;
      rise_r      <= '0;
      fall_r      <= '0;
      wait_r      <= '0;
      round_r     <= '0;
      last_rise_r <= '0;
      last_fall_r <= '0;
      touch_r     <= 1'b0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      rise_r      <= rise_nxt;
      fall_r      <= fall_nxt;
      wait_r      <= wait_nxt;
      round_r     <= round_nxt;
      last_rise_r <= last_rise_nxt;
      last_fall_r <= last_fall_nxt;
      touch_r     <= touch_nxt;
    end
  end

endmodule

// ===== hdl/cts_filt.sv =====
// two-stage low-pass filter update on the rise sum, Q16.16 accumulator
module cts_filt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       load,
  input  logic [cts_pkg::DATA_W-1:0] x,
  input  logic [cts_pkg::DATA_W-1:0] gain,
  output logic [cts_pkg::DATA_W-1:0] smoothed
);

  logic                          d1_r, d2_r;
  logic [cts_pkg::DATA_W-1:0]    x1_r, g1_r;
  logic [cts_pkg::ACC_W-1:0]     px2_r;
  logic [cts_pkg::ACC_W+15:0]    pacc2_r;
  logic [cts_pkg::ACC_W-1:0]     acc_r;
  logic [cts_pkg::ACC_W+16:0]    pacc_rnd;
  logic [cts_pkg::ACC_W:0]       pacc_ceil;
  logic [cts_pkg::ACC_W+1:0]     acc_sum;
  logic [cts_pkg::ACC_W-1:0]     acc_new;

  // acc' = acc + g*x - ceil(g*acc / 2^16)
  assign pacc_rnd  = {1'b0, pacc2_r} + 49'h0_0000_0000_FFFF;
  assign pacc_ceil = pacc_rnd[cts_pkg::ACC_W+16:16];
  assign acc_sum   = {2'b00, acc_r} + {2'b00, px2_r} - {1'b0, pacc_ceil};
  assign acc_new   = acc_sum[cts_pkg::ACC_W-1:0];

  assign smoothed = d2_r ? acc_new[cts_pkg::ACC_W-1:16] : acc_r[cts_pkg::ACC_W-1:16];

  // control flags and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r  <= 1'b0;
      d2_r  <= 1'b0;
      acc_r <= '0;
    end else if (en) begin
      d1_r <= load;
      d2_r <= d1_r;
      if (d2_r) acc_r <= acc_new;
    end
  end

  // operand and product registers
  always_ff @(posedge clk) begin
    if (en) begin
      if (load) begin
        x1_r <= x;
        g1_r <= gain;
      end
      if (d1_r) begin
        px2_r   <= {16'b0, g1_r} * {16'b0, x1_r};
        pacc2_r <= {32'b0, g1_r} * {16'b0, acc_r};
      end
    end
  end

endmodule

// ===== hdl/cts_check.sv =====
// port-level checker for the touch sensor, bound to the top level
`include "assert_macros.svh"

module cts_check (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       drive_level,
  input logic                       done_res,
  input logic [cts_pkg::DATA_W-1:0] rise_sum,
  input logic [cts_pkg::DATA_W-1:0] smoothed
);

  // input side only stalls when a result is waiting and not taken
  `CTS_ASSERT(a_ready_rule, in_ready == (!out_valid || out_ready), "in_ready rule broken")

  // a refused request always sits behind a stalled result
  `CTS_ASSERT(a_refused_stalled, (in_valid && !in_ready) |-> (out_valid && !out_ready), "request refused without stall")

  // a measurement always completes with the charge pin low
  `CTS_ASSERT(a_done_drive_low, (out_valid && done_res) |-> !drive_level, "done while driving")

  // a stalled result holds
  `CTS_ASSERT(a_stall_hold,
              (out_valid && !out_ready) |=>
                (out_valid && $stable(rise_sum) && $stable(smoothed) && $stable(done_res)),
              "stalled result changed")

  // reset empties the result register
  `CTS_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind capacitive_touch_sensor cts_check u_cts_check (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .drive_level (out_if.drive_level),
  .done_res    (out_if.done_res),
  .rise_sum    (out_if.rise_sum),
  .smoothed    (out_if.smoothed)
);

// ===== sim/cts_tick_checker.sv =====
// request/result checker for the capacitive touch sensor, with its own tick predictor
`timescale 1ns / 1ps

module cts_tick_checker
  import cts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  cts_in_if                    in_mon,
  cts_out_if                   out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   pending_ticks,
  output int                   fail_count
);

  typedef struct packed {
    logic              drive_level;
    logic              done_res;
    logic [DATA_W-1:0] rise_sum;
    logic [DATA_W-1:0] fall_sum;
    logic [DATA_W-1:0] smoothed;
    logic              touched;
  } tick_result_t;

  // predicted results still waiting for the block
  tick_result_t expected_ticks[$];
  int errs = 0;

  // register copies
  logic [DATA_W-1:0] gain, thresh, settle;

  // sequencer and filter state
  phase_t            ph;
  logic [DATA_W-1:0] rise_cnt, fall_cnt, wait_cnt;
  int                round_cnt;
  logic [ACC_W-1:0]  acc;
  logic              touch;
  logic [DATA_W-1:0] pub_rise, pub_fall;

  function automatic logic [DATA_W-1:0] count_up(input logic [DATA_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // readable form of one result
  function automatic string show(input tick_result_t r);
    return $sformatf("drive=%0b done=%0b rise=%0d fall=%0d smooth=%0d touch=%0b",
                     r.drive_level, r.done_res, r.rise_sum, r.fall_sum,
                     r.smoothed, r.touched);
  endfunction

  // end of one charge/discharge round, publishes the measurement after the last one
  task automatic close_round(output logic done);
    logic [63:0] mix;
    done = 1'b0;
    if (round_cnt + 1 < REPETITIONS) begin
      round_cnt++;
      ph = PH_CHARGE;
    end else begin
      pub_rise = rise_cnt;
      pub_fall = fall_cnt;
      touch = (rise_cnt > thresh);
      mix = 64'(gain) * {32'd0, rise_cnt, 16'd0} + (64'd65536 - 64'(gain)) * 64'(acc);
      acc = mix[47:16];
      rise_cnt = '0;
      fall_cnt = '0;
      round_cnt = 0;
      wait_cnt = '0;
      ph = PH_CHARGE;
      done = 1'b1;
    end
  endtask

  // one sampling tick of the sensor
  task automatic advance_sensor(input logic sense, output tick_result_t res);
    logic done;
    done = 1'b0;
    res.drive_level = (ph == PH_CHARGE) || (ph == PH_HOLD_HI);
    case (ph)
      PH_CHARGE: begin
        if (!sense) rise_cnt = count_up(rise_cnt);
        else if (settle == '0) ph = PH_DISCHARGE;
        else begin
          wait_cnt = '0;
          ph = PH_HOLD_HI;
        end
      end
      PH_HOLD_HI: begin
        wait_cnt = count_up(wait_cnt);
        if (wait_cnt >= settle) ph = PH_DISCHARGE;
      end
      PH_DISCHARGE: begin
        if (sense) fall_cnt = count_up(fall_cnt);
        else if (settle == '0) close_round(done);
        else begin
          wait_cnt = '0;
          ph = PH_HOLD_LO;
        end
      end
      default: begin
        wait_cnt = count_up(wait_cnt);
        if (wait_cnt >= settle) close_round(done);
      end
    endcase
    res.done_res = done;
    res.rise_sum = pub_rise;
    res.fall_sum = pub_fall;
    res.smoothed = acc[31:16];
    res.touched  = touch;
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    tick_result_t want, got;
    if (!rst_n) begin
      gain = GAIN_RST;
      thresh = THRESH_RST;
      settle = SETTLE_RST;
      ph = PH_CHARGE;
      rise_cnt = '0;
      fall_cnt = '0;
      wait_cnt = '0;
      round_cnt = 0;
      acc = '0;
      touch = 1'b0;
      pub_rise = '0;
      pub_fall = '0;
      expected_ticks.delete();
      errs = 0;
    end else begin
      // compare the result leaving the block
      if (out_mon.valid && out_mon.ready) begin
        got.drive_level = out_mon.drive_level;
        got.done_res    = out_mon.done_res;
        got.rise_sum    = out_mon.rise_sum;
        got.fall_sum    = out_mon.fall_sum;
        got.smoothed    = out_mon.smoothed;
        got.touched     = out_mon.touched;
        if (expected_ticks.size() == 0) begin
          $display("%0t expected no result, actual %s", $time, show(got));
          errs++;
        end else begin
          want = expected_ticks.pop_front();
          if (want !== got) begin
            $display("%0t expected %s", $time, show(want));
            $display("%0t actual   %s", $time, show(got));
            errs++;
          end
        end
      end
      // predict the result of a new request
      if (in_mon.valid && in_mon.ready) begin
        advance_sensor(in_mon.sense_level, want);
        expected_ticks.push_back(want);
      end
      // register writes, unknown indexes ignored
      if (cfg_we) begin
        case (cfg_idx)
          CFG_GAIN:   gain = cfg_data;
          CFG_THRESH: thresh = cfg_data;
          CFG_SETTLE: settle = cfg_data;
          default: ;
        endcase
      end
    end
    pending_ticks <= expected_ticks.size();
    fail_count <= errs;
  end

endmodule

// ===== sim/tb_capacitive_touch_sensor.sv =====
// stimulus and verdict for the capacitive touch sensor testbench
`timescale 1ns / 1ps

module tb_capacitive_touch_sensor;
  import cts_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 150;
  localparam int LONG_RUN      = 40;
  localparam int LONG_STALL    = 120;
  localparam int LONG_STALL_AT = 300;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_data;
  int                   pending_ticks;
  int                   fail_count;
  bit                   quiet_mode = 1'b0;

  cts_in_if  sample_ch();
  cts_out_if result_ch();

  capacitive_touch_sensor DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (sample_ch),
    .out_if  (result_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  cts_tick_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (sample_ch),
    .out_mon      (result_ch),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .pending_ticks(pending_ticks),
    .fail_count   (fail_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("capacitive_touch_sensor: mismatch");
    $finish;
  end

  // result side, random stalls plus one long hold-off
  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = quiet_mode ? 0 : $urandom_range(0, 9);
      if (taken == LONG_STALL_AT) gap = LONG_STALL;
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      taken++;
    end
  end

  // offer one sampling tick as a request
  task automatic offer_sample(input logic level);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sense_level <= level;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
  endtask

  // stop offering until every predicted result has come back
  task automatic wait_for_results();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_ticks != 0);
  endtask

  // reprogram all registers on an idle block, plus a write to the unused index
  task automatic program_registers(input logic [DATA_W-1:0] g, t, s);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_GAIN;
    cfg_data <= g;
    @(posedge clk);
    cfg_idx <= CFG_THRESH;
    cfg_data <= t;
    @(posedge clk);
    cfg_idx <= CFG_SETTLE;
    cfg_data <= s;
    @(posedge clk);
    cfg_idx <= CFG_UNUSED;
    cfg_data <= DATA_W'($urandom_range(0, 65535));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus
  initial begin : stimulus
    logic [DATA_W-1:0] g;
    logic              level;
    int                sent;
    int                run;
    rst_n <= 1'b0;
    sample_ch.valid <= 1'b0;
    sample_ch.sense_level <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_GAIN;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: charge, then sit in the high hold
    offer_sample(1'b0);
    offer_sample(1'b0);
    offer_sample(1'b1);
    offer_sample(1'b1);
    offer_sample(1'b0);
    // longest hold
    program_registers(GAIN_RST, THRESH_RST, 16'hFFFF);
    offer_sample(1'b1);
    offer_sample(1'b1);
    // hold shortened below the count mid-hold, ends on the next tick
    program_registers(GAIN_RST, THRESH_RST, 16'd2);
    offer_sample(1'b0);
    offer_sample(1'b1);
    offer_sample(1'b1);
    offer_sample(1'b0);
    offer_sample(1'b0);
    offer_sample(1'b1);

    // zero settle, full gain, zero threshold: finish the measurement
    program_registers(16'hFFFF, 16'd0, 16'd0);
    offer_sample(1'b0);
    offer_sample(1'b1);
    offer_sample(1'b1);
    offer_sample(1'b0);
    offer_sample(1'b1);
    offer_sample(1'b0);
    offer_sample(1'b0);
    offer_sample(1'b0);
    offer_sample(1'b1);
    offer_sample(1'b1);
    offer_sample(1'b0);

    // random pin waveforms: runs of each level with some noise
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: g = '0;
        1: g = '1;
        default: g = DATA_W'($urandom_range(0, 65535));
      endcase
      program_registers(g, DATA_W'($urandom_range(0, 40)), DATA_W'($urandom_range(0, 5)));
      quiet_mode = (p == 2);
      level = 1'($urandom_range(0, 1));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        repeat (run) begin
          if ($urandom_range(0, 9) == 0) offer_sample(1'($urandom_range(0, 1)));
          else offer_sample(level);
          sent++;
        end
        level = ~level;
      end
      quiet_mode = 1'b0;
    end

    // long runs of each level, highest threshold, back to back
    program_registers(DATA_W'($urandom_range(0, 65535)), 16'hFFFF, 16'd0);
    quiet_mode = 1'b1;
    repeat (LONG_RUN) offer_sample(1'b0);
    repeat (LONG_RUN) offer_sample(1'b1);
    offer_sample(1'b0);
    repeat (REPETITIONS) begin
      offer_sample(1'b1);
      offer_sample(1'b0);
    end
    quiet_mode = 1'b0;

    // drain and let the pipeline settle
    wait_for_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("capacitive_touch_sensor: match");
    end else begin
      $display("capacitive_touch_sensor: mismatch");
    end
    $finish;
  end

endmodule
